// File: rtl/project_point_to_screen_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the point projection block
// Implication checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PROJECT_POINT_TO_SCREEN_TOP_ASSERT_SVH
`define PROJECT_POINT_TO_SCREEN_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PPTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
// next-cycle implication
`define PPTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define PPTS_ASSERT_SAME(label, clk, rst, ante, cons)
`define PPTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/ppts_pkg.sv
// ----------------------------------------------------------------------------
// ppts_pkg
// Shared types, codes and helpers of the point projection block.
// ----------------------------------------------------------------------------
package ppts_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int WORD_W            = 32;
   localparam int CSR_ADDR_W        = 5;
   localparam int CSR_DATA_W        = 32;
   localparam int AXIS_COUNT        = 9;
   localparam int LANES             = 3;
   localparam int SAT_IN_W          = 72;

   // reset values of the registers
   localparam logic [30:0]        RESET_ZOOM = 31'd65536;
   localparam logic signed [31:0] RESET_PROJ = 32'sd65536;

   // action codes
   localparam logic ACT_PROJECT = 1'b0;
   localparam logic ACT_LOAD    = 1'b1;

   // view modes
   localparam logic [1:0] MODE_XY    = 2'd0;
   localparam logic [1:0] MODE_XZ    = 2'd1;
   localparam logic [1:0] MODE_YZ    = 2'd2;
   localparam logic [1:0] MODE_PERSP = 2'd3;

   // register indexes
   localparam logic [2:0] REG_VIEW_MODE = 3'd0;
   localparam logic [2:0] REG_ORIGIN_X  = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Y  = 3'd2;
   localparam logic [2:0] REG_ORIGIN_Z  = 3'd3;
   localparam logic [2:0] REG_ZOOM      = 3'd4;
   localparam logic [2:0] REG_PROJ      = 3'd5;
   localparam logic [2:0] REG_CENTER_X  = 3'd6;
   localparam logic [2:0] REG_CENTER_Y  = 3'd7;

   typedef struct packed {
      logic              action;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic [3:0]         axis_index;
      logic signed [31:0] axis_value;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
      logic signed [31:0] pixel_scale;
      logic               visible;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]         view_mode;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic [30:0]        ortho_zoom;
      logic signed [31:0] proj_distance;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
   } cfg_type;

   // values that ride along with the divider
   typedef struct packed {
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic               sign_x;
      logic               sign_y;
      logic               sign_s;
      logic               visible;
   } div_side_type;

   // clamp a wide signed value to a 32-bit word
   function automatic logic signed [31:0] sat_word(input logic signed [SAT_IN_W-1:0] v);
      logic signed [SAT_IN_W-1:0] vmax;
      logic signed [SAT_IN_W-1:0] vmin;
      logic signed [31:0]         res;
      vmax = {{(SAT_IN_W-31){1'b0}}, {31{1'b1}}};
      vmin = ~vmax;
      if (v > vmax) begin
         res = 32'sh7FFF_FFFF;
      end else if (v < vmin) begin
         res = 32'sh8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

// File: rtl/project_point_to_screen_top.sv
// ----------------------------------------------------------------------------
// project_point_to_screen_top
// 3D point to screen projection, ortho and perspective, fixed point.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 word
//  req       in         req_valid / req_stall     ppts_pkg::req_word_type
//  rsp       out        rsp_valid / rsp_stall     ppts_pkg::rsp_word_type
//  apb       in/out     psel/penable/pready       8 registers at 4*index
//
//  One word enters per cycle while req_stall is low; a projection is offered
//  on rsp after 4 front stages, 33 + FRAC_BITS divider stages, 2 post stages
//  and the output register. Loads give no result and write the axis matrix
//  as they leave the first stage.
//  Synchronous reset restores registers and an identity matrix at once.
//  A stalled rsp fills one skid word, then req_stall holds the pipeline.
// ----------------------------------------------------------------------------
module project_point_to_screen_top #(
   parameter int FRAC_BITS = ppts_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ppts_pkg::req_word_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ppts_pkg::rsp_word_type              rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ppts_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ppts_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ppts_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int NUM_W = 33 + FRAC_BITS;

   ppts_pkg::cfg_type           cfg;
   logic                        adv;
   logic                        div_in_valid;
   logic [NUM_W-1:0]            div_in_num [ppts_pkg::LANES];
   logic [ppts_pkg::WORD_W-1:0] div_in_den [ppts_pkg::LANES];
   ppts_pkg::div_side_type      div_in_side;
   logic                        div_out_valid;
   logic [NUM_W-1:0]            div_out_quo [ppts_pkg::LANES];
   ppts_pkg::div_side_type      div_out_side;

   assign req_stall = !adv;

   ppts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ppts_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_word   (req_data),
      .cfg       (cfg),
      .out_valid (div_in_valid),
      .out_num   (div_in_num),
      .out_den   (div_in_den),
      .out_side  (div_in_side)
   );

   ppts_div #(.NUM_W(NUM_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_in_valid),
      .in_num    (div_in_num),
      .in_den    (div_in_den),
      .in_side   (div_in_side),
      .out_valid (div_out_valid),
      .out_quo   (div_out_quo),
      .out_side  (div_out_side)
   );

   ppts_post #(.FRAC_BITS(FRAC_BITS)) u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_out_valid),
      .in_quo    (div_out_quo),
      .in_side   (div_out_side),
      .cfg       (cfg),
      .rsp_stall (rsp_stall),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/ppts_csr.sv
// ----------------------------------------------------------------------------
// ppts_csr
// Register file behind the APB-style port.
// ----------------------------------------------------------------------------
module ppts_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ppts_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ppts_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ppts_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output ppts_pkg::cfg_type                   cfg
);

   logic [2:0]        reg_idx;
   logic              wr_en;
   ppts_pkg::cfg_type cfg_ff;
   ppts_pkg::cfg_type cfg_in;

   assign reg_idx = paddr[ppts_pkg::CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // next register values
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            ppts_pkg::REG_VIEW_MODE: cfg_in.view_mode     = pwdata[1:0];
            ppts_pkg::REG_ORIGIN_X:  cfg_in.origin_x      = $signed(pwdata);
            ppts_pkg::REG_ORIGIN_Y:  cfg_in.origin_y      = $signed(pwdata);
            ppts_pkg::REG_ORIGIN_Z:  cfg_in.origin_z      = $signed(pwdata);
            ppts_pkg::REG_ZOOM:      cfg_in.ortho_zoom    = pwdata[30:0];
            ppts_pkg::REG_PROJ:      cfg_in.proj_distance = $signed(pwdata);
            ppts_pkg::REG_CENTER_X:  cfg_in.center_x      = $signed(pwdata);
            ppts_pkg::REG_CENTER_Y:  cfg_in.center_y      = $signed(pwdata);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_mode     <= ppts_pkg::MODE_PERSP;
         cfg_ff.origin_x      <= '0;
         cfg_ff.origin_y      <= '0;
         cfg_ff.origin_z      <= '0;
         cfg_ff.ortho_zoom    <= ppts_pkg::RESET_ZOOM;
         cfg_ff.proj_distance <= ppts_pkg::RESET_PROJ;
         cfg_ff.center_x      <= '0;
         cfg_ff.center_y      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         ppts_pkg::REG_VIEW_MODE: prdata = {30'd0, cfg_ff.view_mode};
         ppts_pkg::REG_ORIGIN_X:  prdata = cfg_ff.origin_x;
         ppts_pkg::REG_ORIGIN_Y:  prdata = cfg_ff.origin_y;
         ppts_pkg::REG_ORIGIN_Z:  prdata = cfg_ff.origin_z;
         ppts_pkg::REG_ZOOM:      prdata = {1'b0, cfg_ff.ortho_zoom};
         ppts_pkg::REG_PROJ:      prdata = cfg_ff.proj_distance;
         ppts_pkg::REG_CENTER_X:  prdata = cfg_ff.center_x;
         ppts_pkg::REG_CENTER_Y:  prdata = cfg_ff.center_y;
      endcase
   end

endmodule

// File: rtl/ppts_front.sv
// ----------------------------------------------------------------------------
// ppts_front
// Origin subtract, axis matrix store, rotation and divider operand setup.
// ----------------------------------------------------------------------------
module ppts_front #(
   parameter  int FRAC_BITS = ppts_pkg::FRAC_BITS_DEFAULT,
   localparam int NUM_W     = 33 + FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  ppts_pkg::req_word_type       in_word,
   input  ppts_pkg::cfg_type            cfg,
   output logic                         out_valid,
   output logic [NUM_W-1:0]             out_num [ppts_pkg::LANES],
   output logic [ppts_pkg::WORD_W-1:0]  out_den [ppts_pkg::LANES],
   output ppts_pkg::div_side_type       out_side
);

   localparam int T_W    = 33;
   localparam int PROD_W = 65 - FRAC_BITS;
   localparam int SUM_W  = PROD_W + 2;
   localparam int ONE_I  = 1 << FRAC_BITS;
   localparam int C001_I = (ONE_I + 50) / 100;
   localparam int C002_I = (2 * ONE_I + 50) / 100;
   localparam logic signed [31:0] ONE  = 32'(ONE_I);
   localparam logic signed [31:0] C001 = 32'(C001_I);
   localparam logic signed [31:0] C002 = 32'(C002_I);

   // stage 1: point minus origin
   logic                 s1_valid_ff;
   logic                 s1_load_ff;
   logic signed [T_W-1:0] s1_t_ff [3];
   logic [3:0]           s1_idx_ff;
   logic signed [31:0]   s1_val_ff;
   logic signed [T_W-1:0] t_in [3];

   assign t_in[0] = T_W'(in_word.coord_x) - T_W'(cfg.origin_x);
   assign t_in[1] = T_W'(in_word.coord_y) - T_W'(cfg.origin_y);
   assign t_in[2] = T_W'(in_word.coord_z) - T_W'(cfg.origin_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_load_ff <= (in_word.action == ppts_pkg::ACT_LOAD);
         s1_t_ff    <= t_in;
         s1_idx_ff  <= in_word.axis_index;
         s1_val_ff  <= in_word.axis_value;
      end
   end

   // axis matrix, written in order with the projections behind it
   logic signed [31:0] axes_ff [ppts_pkg::AXIS_COUNT];
   logic               axis_wr;

   assign axis_wr = adv && s1_valid_ff && s1_load_ff
                    && (s1_idx_ff < 4'(ppts_pkg::AXIS_COUNT));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ppts_pkg::AXIS_COUNT; i++) begin
            axes_ff[i] <= (i % 4 == 0) ? ONE : 32'sd0;   // identity
         end
      end else if (axis_wr) begin
         axes_ff[s1_idx_ff] <= s1_val_ff;
      end
   end

   // stage 2: nine products, floored to the fixed point
   logic                   s2_valid_ff;
   logic signed [PROD_W-1:0] s2_prod_ff [ppts_pkg::AXIS_COUNT];
   logic signed [T_W-1:0]  s2_t_ff [3];
   logic signed [64:0]     prod_full [ppts_pkg::AXIS_COUNT];
   logic signed [PROD_W-1:0] prod_in [ppts_pkg::AXIS_COUNT];

   always_comb begin
      for (int i = 0; i < ppts_pkg::AXIS_COUNT; i++) begin
         prod_full[i] = 65'(axes_ff[i]) * 65'(s1_t_ff[i % 3]);
         prod_in[i]   = PROD_W'(prod_full[i] >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && !s1_load_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_prod_ff <= prod_in;
         s2_t_ff    <= s1_t_ff;
      end
   end

   // stage 3: row sums, clamped
   logic                  s3_valid_ff;
   logic signed [31:0]    s3_r_ff [3];
   logic signed [T_W-1:0] s3_t_ff [3];
   logic signed [SUM_W-1:0] sum_w [3];
   logic signed [31:0]    r_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_w[i] = SUM_W'(s2_prod_ff[3*i]) + SUM_W'(s2_prod_ff[3*i+1])
                    + SUM_W'(s2_prod_ff[3*i+2]);
         r_in[i]  = ppts_pkg::sat_word(ppts_pkg::SAT_IN_W'(sum_w[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_r_ff <= r_in;
         s3_t_ff <= s2_t_ff;
      end
   end

   // stage 4: depth nudge, magnitudes and signs for the divider
   logic signed [31:0]       z_adj;
   logic signed [32:0]       z_wide;
   logic [32:0]              z_mag;
   logic signed [32:0]       p_wide;
   logic [32:0]              p_mag;
   logic [32:0]              t_mag [3];
   logic [30:0]              zoom_eff;
   logic [NUM_W-1:0]         num_in [ppts_pkg::LANES];
   logic [ppts_pkg::WORD_W-1:0] den_in [ppts_pkg::LANES];
   ppts_pkg::div_side_type   side_in;
   logic                     s4_valid_ff;
   logic [NUM_W-1:0]         s4_num_ff [ppts_pkg::LANES];
   logic [ppts_pkg::WORD_W-1:0] s4_den_ff [ppts_pkg::LANES];
   ppts_pkg::div_side_type   s4_side_ff;

   always_comb begin
      z_adj = s3_r_ff[2];
      if (z_adj > -C001 && z_adj < C001) begin
         z_adj = z_adj + C002;
      end
      z_wide = 33'(z_adj);
      z_mag  = z_wide[32] ? 33'(-z_wide) : 33'(z_wide);
      p_wide = 33'(cfg.proj_distance);
      p_mag  = p_wide[32] ? 33'(-p_wide) : 33'(p_wide);
      for (int i = 0; i < 3; i++) begin
         t_mag[i] = s3_t_ff[i][32] ? 33'(-s3_t_ff[i]) : 33'(s3_t_ff[i]);
      end
      zoom_eff = (cfg.ortho_zoom == '0) ? 31'd1 : cfg.ortho_zoom;

      if (cfg.view_mode == ppts_pkg::MODE_PERSP) begin
         num_in[0]       = '0;
         num_in[1]       = '0;
         num_in[2]       = NUM_W'(p_mag) << FRAC_BITS;
         den_in[0]       = 32'd1;
         den_in[1]       = 32'd1;
         den_in[2]       = z_mag[31:0];
         side_in.r_x     = s3_r_ff[0];
         side_in.r_y     = s3_r_ff[1];
         side_in.sign_x  = 1'b0;
         side_in.sign_y  = 1'b0;
         side_in.sign_s  = cfg.proj_distance[31] ^ z_adj[31];
         side_in.visible = (z_adj > ONE);
      end else begin
         // horizontal axis is Y in YZ mode, else X
         if (cfg.view_mode == ppts_pkg::MODE_YZ) begin
            num_in[0]      = NUM_W'(t_mag[1]) << FRAC_BITS;
            side_in.sign_x = s3_t_ff[1][32];
         end else begin
            num_in[0]      = NUM_W'(t_mag[0]) << FRAC_BITS;
            side_in.sign_x = s3_t_ff[0][32];
         end
         // vertical axis is Y in XY mode, else negated Z
         if (cfg.view_mode == ppts_pkg::MODE_XY) begin
            num_in[1]      = NUM_W'(t_mag[1]) << FRAC_BITS;
            side_in.sign_y = s3_t_ff[1][32];
         end else begin
            num_in[1]      = NUM_W'(t_mag[2]) << FRAC_BITS;
            side_in.sign_y = !s3_t_ff[2][32];
         end
         num_in[2]       = NUM_W'(1) << (2 * FRAC_BITS);
         den_in[0]       = 32'(zoom_eff);
         den_in[1]       = 32'(zoom_eff);
         den_in[2]       = 32'(zoom_eff);
         side_in.r_x     = '0;
         side_in.r_y     = '0;
         side_in.sign_s  = 1'b0;
         side_in.visible = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_num_ff  <= num_in;
         s4_den_ff  <= den_in;
         s4_side_ff <= side_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_num   = s4_num_ff;
   assign out_den   = s4_den_ff;
   assign out_side  = s4_side_ff;

endmodule

// File: rtl/ppts_div.sv
// ----------------------------------------------------------------------------
// ppts_div
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ppts_div #(
   parameter int NUM_W = 33 + ppts_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [NUM_W-1:0]             in_num [ppts_pkg::LANES],
   input  logic [ppts_pkg::WORD_W-1:0]  in_den [ppts_pkg::LANES],
   input  ppts_pkg::div_side_type       in_side,
   output logic                         out_valid,
   output logic [NUM_W-1:0]             out_quo [ppts_pkg::LANES],
   output ppts_pkg::div_side_type       out_side
);

   localparam int DEN_W = ppts_pkg::WORD_W;
   localparam int LANES = ppts_pkg::LANES;

   // stage registers; work holds numerator bits on top, quotient bits below
   logic                   vld_ff  [NUM_W];
   logic [NUM_W-1:0]       work_ff [NUM_W][LANES];
   logic [DEN_W-1:0]       rem_ff  [NUM_W][LANES];
   logic [DEN_W-1:0]       den_ff  [NUM_W][LANES];
   ppts_pkg::div_side_type side_ff [NUM_W];

   logic                   vld_src  [NUM_W];
   logic [NUM_W-1:0]       work_src [NUM_W][LANES];
   logic [DEN_W-1:0]       rem_src  [NUM_W][LANES];
   logic [DEN_W-1:0]       den_src  [NUM_W][LANES];
   ppts_pkg::div_side_type side_src [NUM_W];

   logic [NUM_W-1:0]       work_in  [NUM_W][LANES];
   logic [DEN_W-1:0]       rem_in   [NUM_W][LANES];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W:0] trial [LANES];

      // stage source
      if (k == 0) begin : g_head
         always_comb begin
            vld_src[k]  = in_valid;
            side_src[k] = in_side;
            for (int l = 0; l < LANES; l++) begin
               work_src[k][l] = in_num[l];
               rem_src[k][l]  = '0;
               den_src[k][l]  = in_den[l];
            end
         end
      end else begin : g_tail
         always_comb begin
            vld_src[k]  = vld_ff[k-1];
            side_src[k] = side_ff[k-1];
            for (int l = 0; l < LANES; l++) begin
               work_src[k][l] = work_ff[k-1][l];
               rem_src[k][l]  = rem_ff[k-1][l];
               den_src[k][l]  = den_ff[k-1][l];
            end
         end
      end

      // one shift, compare and subtract per lane
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            trial[l] = {rem_src[k][l], work_src[k][l][NUM_W-1]};
            if (trial[l] >= {1'b0, den_src[k][l]}) begin
               rem_in[k][l]  = DEN_W'(trial[l] - {1'b0, den_src[k][l]});
               work_in[k][l] = {work_src[k][l][NUM_W-2:0], 1'b1};
            end else begin
               rem_in[k][l]  = trial[l][DEN_W-1:0];
               work_in[k][l] = {work_src[k][l][NUM_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            work_ff[k] <= work_in[k];
            rem_ff[k]  <= rem_in[k];
            den_ff[k]  <= den_src[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quo   = work_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// File: rtl/ppts_post.sv
// ----------------------------------------------------------------------------
// ppts_post
// Quotient signs, scale products, center offset and the output buffer.
// ----------------------------------------------------------------------------
module ppts_post #(
   parameter  int FRAC_BITS = ppts_pkg::FRAC_BITS_DEFAULT,
   localparam int NUM_W     = 33 + FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [NUM_W-1:0]        in_quo [ppts_pkg::LANES],
   input  ppts_pkg::div_side_type  in_side,
   input  ppts_pkg::cfg_type       cfg,
   input  logic                    rsp_stall,
   output logic                    adv,
   output logic                    rsp_valid,
   output ppts_pkg::rsp_word_type  rsp_data
);

   `include "project_point_to_screen_top_assert.svh"

   localparam int QS_W = NUM_W + 1;

   logic                  skid_valid_ff;
   logic                  rsp_valid_ff;

   assign adv = !skid_valid_ff;

   // stage 1: signed quotients, ortho results, clamped reciprocal
   logic signed [QS_W-1:0] qs [ppts_pkg::LANES];
   logic signed [31:0]     sx_orth;
   logic signed [31:0]     sy_orth;
   logic signed [31:0]     rz_in;
   logic                   p1_valid_ff;
   logic signed [31:0]     p1_sx_ff, p1_sy_ff, p1_rz_ff, p1_rx_ff, p1_ry_ff;
   logic                   p1_vis_ff;

   always_comb begin
      qs[0] = in_side.sign_x ? -$signed({1'b0, in_quo[0]}) : $signed({1'b0, in_quo[0]});
      qs[1] = in_side.sign_y ? -$signed({1'b0, in_quo[1]}) : $signed({1'b0, in_quo[1]});
      qs[2] = in_side.sign_s ? -$signed({1'b0, in_quo[2]}) : $signed({1'b0, in_quo[2]});
      sx_orth = ppts_pkg::sat_word(ppts_pkg::SAT_IN_W'(qs[0])
                                   + ppts_pkg::SAT_IN_W'(cfg.center_x));
      sy_orth = ppts_pkg::sat_word(ppts_pkg::SAT_IN_W'(qs[1])
                                   + ppts_pkg::SAT_IN_W'(cfg.center_y));
      rz_in   = ppts_pkg::sat_word(ppts_pkg::SAT_IN_W'(qs[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_sx_ff  <= sx_orth;
         p1_sy_ff  <= sy_orth;
         p1_rz_ff  <= rz_in;
         p1_rx_ff  <= in_side.r_x;
         p1_ry_ff  <= in_side.r_y;
         p1_vis_ff <= in_side.visible;
      end
   end

   // stage 2: rotated X and Y times the reciprocal
   logic                p2_valid_ff;
   logic signed [63:0]  p2_px_ff, p2_py_ff;
   logic signed [31:0]  p2_sx_ff, p2_sy_ff, p2_rz_ff;
   logic                p2_vis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_px_ff  <= 64'(p1_rx_ff) * 64'(p1_rz_ff);
         p2_py_ff  <= 64'(p1_ry_ff) * 64'(p1_rz_ff);
         p2_sx_ff  <= p1_sx_ff;
         p2_sy_ff  <= p1_sy_ff;
         p2_rz_ff  <= p1_rz_ff;
         p2_vis_ff <= p1_vis_ff;
      end
   end

   // final word: perspective results floored, offset by center and clamped
   ppts_pkg::rsp_word_type push_data;
   logic                   push;

   assign push = adv && p2_valid_ff;

   always_comb begin
      if (cfg.view_mode == ppts_pkg::MODE_PERSP) begin
         push_data.screen_x = ppts_pkg::sat_word(ppts_pkg::SAT_IN_W'(p2_px_ff >>> FRAC_BITS)
                                                 + ppts_pkg::SAT_IN_W'(cfg.center_x));
         push_data.screen_y = ppts_pkg::sat_word(ppts_pkg::SAT_IN_W'(p2_py_ff >>> FRAC_BITS)
                                                 + ppts_pkg::SAT_IN_W'(cfg.center_y));
      end else begin
         push_data.screen_x = p2_sx_ff;
         push_data.screen_y = p2_sy_ff;
      end
      push_data.pixel_scale = p2_rz_ff;
      push_data.visible     = p2_vis_ff;
   end

   // output register plus one skid entry
   ppts_pkg::rsp_word_type rsp_data_ff;
   ppts_pkg::rsp_word_type skid_data_ff;
   logic                   pop;
   logic                   out_free;

   assign pop      = rsp_valid_ff && !rsp_stall;
   assign out_free = !rsp_valid_ff || pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= skid_valid_ff || push;
         end
         if (skid_valid_ff) begin
            if (out_free) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (push && !out_free) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : push_data;
      end
      if (!skid_valid_ff) begin
         skid_data_ff <= push_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the skid entry only fills behind a held output word
   `PPTS_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   // a word arriving at a stalled output lands in the skid entry
   `PPTS_ASSERT_NEXT(a_skid_fill, clock, reset, push && rsp_valid_ff && rsp_stall, skid_valid_ff)
   // a taken output word frees the skid entry
   `PPTS_ASSERT_NEXT(a_skid_drain, clock, reset, skid_valid_ff && !rsp_stall, !skid_valid_ff)

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Point projection testbench
// Drives words into the projection block, predicts each screen result in
// fixed point and checks every result field, across ortho and perspective
// views, matrix loads, random idles on both sides and long back-pressure.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC      = 16;
   localparam int CYCLE_CAP = 400000;
   localparam int SETTLE    = 80;      // beyond the pipeline latency

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   ppts_pkg::req_word_type                req_data;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   ppts_pkg::rsp_word_type                rsp_data;
   logic                                  psel;
   logic                                  penable;
   logic                                  pwrite;
   logic [ppts_pkg::CSR_ADDR_W-1:0]       paddr;
   logic [ppts_pkg::CSR_DATA_W-1:0]       pwdata;
   logic [ppts_pkg::CSR_DATA_W-1:0]       prdata;
   logic                                  pready;

   project_point_to_screen_top #(.FRAC_BITS(FRAC)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor copy of registers and matrix
   logic [1:0]         view_sel;
   logic signed [31:0] cam_x, cam_y, cam_z;
   logic [30:0]        zoom_val;
   logic signed [31:0] proj_num;
   logic signed [31:0] mid_x, mid_y;
   logic signed [31:0] axis_mat [9];

   ppts_pkg::rsp_word_type screen_due [$];
   int           error_count;
   int           cycle_count;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           hold_left;

   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // receiver stall: long hold-off first, else random idling
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic logic signed [31:0] clamp32(logic signed [71:0] v);
      if (v > 72'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -72'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      ppts_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (screen_due.size() == 0) begin
            report("unexpected word", rsp_data.screen_x, 32'd0);
         end else begin
            want = screen_due.pop_front();
            if (rsp_data.screen_x !== want.screen_x)
               report("screen_x", rsp_data.screen_x, want.screen_x);
            if (rsp_data.screen_y !== want.screen_y)
               report("screen_y", rsp_data.screen_y, want.screen_y);
            if (rsp_data.pixel_scale !== want.pixel_scale)
               report("pixel_scale", rsp_data.pixel_scale, want.pixel_scale);
            if (rsp_data.visible !== want.visible)
               report("visible", 32'(rsp_data.visible), 32'(want.visible));
         end
      end
   end

   // expected screen word for one accepted point word; loads update the matrix copy
   function automatic void project_point(ppts_pkg::req_word_type w);
      logic signed [71:0] one, t0, t1, t2, r [3], acc, zm, a, b, z, rz;
      logic signed [71:0] sx, sy, sc, c001, c002;
      ppts_pkg::rsp_word_type o;
      one  = 72'sd1 <<< FRAC;
      c001 = (one + 72'sd50) / 72'sd100;
      c002 = (72'sd2 * one + 72'sd50) / 72'sd100;
      if (w.action == ppts_pkg::ACT_LOAD) begin
         if (w.axis_index < ppts_pkg::AXIS_COUNT) axis_mat[w.axis_index] = w.axis_value;
         return;
      end
      t0 = $signed(w.coord_x);  t0 = t0 - $signed(cam_x);
      t1 = $signed(w.coord_y);  t1 = t1 - $signed(cam_y);
      t2 = $signed(w.coord_z);  t2 = t2 - $signed(cam_z);
      o.visible = 1'b1;
      if (view_sel != ppts_pkg::MODE_PERSP) begin
         zm = $signed({41'b0, zoom_val});
         if (zoom_val == 0) zm = 72'sd1;
         a = (view_sel == ppts_pkg::MODE_YZ) ? t1 : t0;
         b = (view_sel == ppts_pkg::MODE_XY) ? t1 : -t2;
         sx = (a * one) / zm + $signed(mid_x);
         sy = (b * one) / zm + $signed(mid_y);
         sc = (one * one) / zm;
      end else begin
         for (int i = 0; i < 3; i++) begin
            acc = ((axis_mat[i*3] * t0) >>> FRAC)
                + ((axis_mat[i*3+1] * t1) >>> FRAC)
                + ((axis_mat[i*3+2] * t2) >>> FRAC);
            r[i] = clamp32(acc);
         end
         z = r[2];
         // depth near zero gets pushed off it
         if (z > -c001 && z < c001) z = z + c002;
         rz = $signed(proj_num);
         rz = clamp32((rz * one) / z);
         sx = ((r[0] * rz) >>> FRAC) + $signed(mid_x);
         sy = ((r[1] * rz) >>> FRAC) + $signed(mid_y);
         sc = rz;
         o.visible = (z > one);
      end
      o.screen_x    = clamp32(sx);
      o.screen_y    = clamp32(sy);
      o.pixel_scale = clamp32(sc);
      screen_due.push_back(o);
   endfunction

   // send one word, with a random idle ahead of it
   task automatic send_word(ppts_pkg::req_word_type w);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      project_point(w);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      stop_sending();
      while (screen_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ppts_pkg::CSR_ADDR_W'(idx) << 2;
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         ppts_pkg::REG_VIEW_MODE: view_sel = val[1:0];
         ppts_pkg::REG_ORIGIN_X:  cam_x    = val;
         ppts_pkg::REG_ORIGIN_Y:  cam_y    = val;
         ppts_pkg::REG_ORIGIN_Z:  cam_z    = val;
         ppts_pkg::REG_ZOOM:      zoom_val = val[30:0];
         ppts_pkg::REG_PROJ:      proj_num = val;
         ppts_pkg::REG_CENTER_X:  mid_x    = val;
         ppts_pkg::REG_CENTER_Y:  mid_y    = val;
         default: ;
      endcase
   endtask

   task automatic write_all(logic [1:0] m, logic [31:0] ox, logic [31:0] oy,
                            logic [31:0] oz, logic [31:0] zm, logic [31:0] pd,
                            logic [31:0] cx, logic [31:0] cy);
      csr_write(ppts_pkg::REG_VIEW_MODE, {30'b0, m});
      csr_write(ppts_pkg::REG_ORIGIN_X, ox);
      csr_write(ppts_pkg::REG_ORIGIN_Y, oy);
      csr_write(ppts_pkg::REG_ORIGIN_Z, oz);
      csr_write(ppts_pkg::REG_ZOOM, zm);
      csr_write(ppts_pkg::REG_PROJ, pd);
      csr_write(ppts_pkg::REG_CENTER_X, cx);
      csr_write(ppts_pkg::REG_CENTER_Y, cy);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(4))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2097152)) - 1048576);
         2: return 32'($signed($urandom_range(131072)) - 65536);
         3: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(200000000)) - 100000000);
      endcase
   endfunction

   function automatic ppts_pkg::req_word_type point_word(logic [31:0] x,
                                                         logic [31:0] y,
                                                         logic [31:0] z);
      ppts_pkg::req_word_type w;
      w.action     = ppts_pkg::ACT_PROJECT;
      w.coord_x    = x;
      w.coord_y    = y;
      w.coord_z    = z;
      w.axis_index = 4'($urandom);
      w.axis_value = $urandom;
      return w;
   endfunction

   function automatic ppts_pkg::req_word_type load_word(logic [3:0] idx,
                                                        logic [31:0] v);
      ppts_pkg::req_word_type w;
      w.action     = ppts_pkg::ACT_LOAD;
      w.coord_x    = $urandom;
      w.coord_y    = $urandom;
      w.coord_z    = $urandom;
      w.axis_index = idx;
      w.axis_value = v;
      return w;
   endfunction

   function automatic ppts_pkg::req_word_type random_word();
      if ($urandom_range(9) < 2)
         return load_word(($urandom_range(7) == 0) ? 4'($urandom) :
                          4'($urandom_range(8)), pick_value());
      return point_word(pick_value(), pick_value(), pick_value());
   endfunction

   task automatic random_config();
      write_all(2'($urandom), pick_value(), pick_value(), pick_value(),
                ($urandom_range(5) == 0) ? $urandom : $urandom_range(1, 400000),
                pick_value(), pick_value(), pick_value());
   endtask

   // ortho views, extreme fields, zero zoom
   task automatic test_ortho_views();
      for (int m = ppts_pkg::MODE_XY; m <= ppts_pkg::MODE_YZ; m++) begin
         write_all(2'(m), 32'd65536, 32'hFFFF_0000, 32'd3, 32'd0,
                   32'd65536, 32'd1000, 32'hFFFF_FC18);
         send_word(point_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
         send_word(point_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
         send_word(point_word(32'd131072, 32'hFFFE_0000, 32'd0));
         drain();
      end
      write_all(ppts_pkg::MODE_XY, 0, 0, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                32'h8000_0000);
      send_word(point_word(32'h7FFF_FFFF, 32'h8000_0000, 0));
      send_word(point_word(0, 0, 0));
      drain();
   endtask

   // perspective: matrix loads, near-zero depth, behind viewer, bad index
   task automatic test_perspective();
      write_all(ppts_pkg::MODE_PERSP, 0, 0, 0, 32'd65536, 32'd65536 * 256, 0, 0);
      send_word(point_word(32'd65536, 32'd65536, 32'd65536 * 4));
      send_word(point_word(32'd65536, 32'd65536, 32'd100));
      send_word(point_word(32'd65536, 32'd65536, 32'hFFFF_FF9C));
      send_word(point_word(32'd65536, 32'd65536, 32'hFFFE_0000));
      send_word(point_word(32'd5, 32'd5, 32'd655));
      send_word(load_word(4'd15, 32'h1234_5678));
      send_word(load_word(4'd9, 32'h8000_0000));
      send_word(load_word(4'd0, 32'h8000_0000));
      send_word(load_word(4'd4, 32'h7FFF_FFFF));
      send_word(load_word(4'd8, 32'hFFFF_0000));
      send_word(point_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
      send_word(point_word(32'd65536, 32'hFFFF_0000, 32'hFFF0_0000));
      drain();
      write_all(ppts_pkg::MODE_PERSP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'd1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(point_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      send_word(point_word(0, 0, 0));
      drain();
   endtask

   // random stream under one idling mix
   task automatic test_random(int tx_pct, int rx_pct, int count);
      send_idle_pct = tx_pct;
      recv_idle_pct = rx_pct;
      for (int k = 0; k < count; k++) begin
         if (k % 60 == 0) begin
            drain();
            random_config();
         end
         // full matrix load, entries in [-1.0, 1.0] fixed point, then the next word
         if ($urandom_range(9) == 0) begin
            for (int i = 0; i < ppts_pkg::AXIS_COUNT; i++)
               send_word(load_word(4'(i), 32'($signed($urandom_range(131072)) - 65536)));
         end
         send_word(random_word());
      end
      drain();
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_config();
      hold_left = 400;
      for (int k = 0; k < 120; k++) send_word(random_word());
      // sender pauses until all results are out
      stop_sending();
      while (screen_due.size() != 0) @(posedge clock);
      for (int k = 0; k < 30; k++) send_word(random_word());
      drain();
   endtask

   initial begin
      clock = 1'b0;  reset = 1'b1;
      req_valid = 1'b0;  req_data = '0;  rsp_stall = 1'b0;
      psel = 1'b0;  penable = 1'b0;  pwrite = 1'b0;  paddr = '0;  pwdata = '0;
      error_count = 0;  cycle_count = 0;  hold_left = 0;
      send_idle_pct = 0;  recv_idle_pct = 0;
      view_sel = ppts_pkg::MODE_PERSP;  cam_x = 0;  cam_y = 0;  cam_z = 0;
      zoom_val = ppts_pkg::RESET_ZOOM;  proj_num = ppts_pkg::RESET_PROJ;
      mid_x = 0;  mid_y = 0;
      for (int i = 0; i < ppts_pkg::AXIS_COUNT; i++)
         axis_mat[i] = (i % 4 == 0) ? 32'sd65536 : 32'sd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset state first, with the identity matrix
      send_word(point_word(32'd65536, 32'd131072, 32'd196608));
      drain();
      test_ortho_views();
      test_perspective();
      test_random(16, 85, 100);
      test_random(85, 16, 100);
      test_random(0, 0, 100);
      test_backpressure();
      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule

// File: sim.f
+incdir+rtl
rtl/ppts_pkg.sv
rtl/ppts_csr.sv
rtl/ppts_front.sv
rtl/ppts_div.sv
rtl/ppts_post.sv
rtl/project_point_to_screen_top.sv
verif/testbench.sv
